[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QRRT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QRRT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

[design/qrrt_pkg.sv]
package qrrt_pkg;

  localparam int WIDE = 128;  // residual and product width
  localparam int CW   = 20;   // c_value port width
  localparam int BW   = 22;   // b_value and root_a width
  localparam int KW   = 8;    // target_multiplier width
  localparam int NW   = 16;   // family_sum width
  localparam int MPW  = 2 * BW;  // widest multiplier operand (b squared)
  localparam int GW   = 22;   // gcd operand width
  localparam int AW   = 3;    // paddr width
  localparam int DW   = 32;   // APB data width

  typedef enum logic [1:0] {
    ST_NEG  = 2'd0,
    ST_ZERO = 2'd1,
    ST_NOTP = 2'd2,
    ST_HIT  = 2'd3
  } status_t;

  typedef enum logic {
    REG_K = 1'b0,
    REG_N = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [KW-1:0] k;
    logic [NW-1:0] n;
  } cfg_regs_t;

  typedef struct packed {
    logic            sub;
    logic [WIDE-1:0] a;
    logic [WIDE-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            cout;
    logic [WIDE-1:0] sum;
  } alu_rsp_t;

endpackage

[design/qrrt_if.sv]
interface qrrt_in_if import qrrt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] c_value;
  logic [BW-1:0] b_value;

  modport source (output valid, output c_value, output b_value, input ready);
  modport sink (input valid, input c_value, input b_value, output ready);
endinterface

interface qrrt_out_if import qrrt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [BW-1:0] root_a;
  logic [CW-1:0] common_divisor;

  modport source (output valid, output status, output root_a, output common_divisor,
                  input ready);
  modport sink (input valid, input status, input root_a, input common_divisor,
                output ready);
endinterface

[design/qrrt_alu.sv]
module qrrt_alu import qrrt_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WIDE:0] total;

  // Subtract as add of the complement plus one; carry out high means no borrow.
  assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + (WIDE+1)'(req.sub);
  assign rsp.sum  = total[WIDE-1:0];
  assign rsp.cout = total[WIDE];

endmodule

[design/qrrt_cfg.sv]
module qrrt_cfg import qrrt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output cfg_regs_t     regs
);

  logic [KW-1:0] k_r;
  logic [NW-1:0] n_r;
  reg_idx_t      idx;

  assign idx    = reg_idx_t'(paddr[AW-1]);
  assign pready = 1'b1;
  assign regs   = '{k: k_r, n: n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= KW'(51);
      n_r <= NW'(2);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_K: k_r <= pwdata[KW-1:0];
        REG_N: n_r <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_K: prdata = DW'(k_r);
      REG_N: prdata = DW'(n_r);
      default: prdata = '0;
    endcase
  end

endmodule

[design/quartic_residual_root_test.sv]
// Quartic residual root test. Each request (c, b) forms r = k*c^4 - N*b^4
// exactly in 128 bits, k and N coming from the APB registers at 0x0 and 0x4,
// and returns one result: negative, zero, positive but not a fourth power, or
// a hit with the integer fourth root a and gcd(a, b, c). Everything runs on
// one shared 128-bit adder/subtractor under a small sequencer: shift-add
// multiplies (one multiplier bit per cycle, stopping once the multiplier is
// spent), a compare, two bitwise square roots (one root bit per cycle, the
// fourth root being the root of the root) and a binary gcd (one shift,
// subtract or swap per cycle). The input is held not ready from acceptance
// until the result is loaded into the output register, while a finished
// result waits in the output register without holding up the next request.
// C_BITS narrows the used part of c_value, which shortens the roots.
`include "assert_macros.svh"

module quartic_residual_root_test import qrrt_pkg::*; #(
  parameter int C_BITS = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  qrrt_in_if.sink       in_req,
  qrrt_out_if.source    out_rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready
);

  localparam int CEFF = (C_BITS < CW) ? C_BITS : CW;
  localparam int LW   = KW + 4 * CEFF;     // bound on the residual width
  localparam int S1N  = (LW + 1) / 2;      // root bits of the first square root
  localparam int S2N  = (S1N + 1) / 2;     // root bits of the second square root
  localparam int SH1  = WIDE - 2 * S1N;
  localparam int SH2  = WIDE - 2 * S2N;
  localparam int CNTW = $clog2(S1N);
  localparam int GKW  = $clog2(GW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CMP, S_SQ1, S_SQ2, S_GCD, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_CSQ, OP_CQU, OP_KMUL, OP_BSQ, OP_BQU, OP_NMUL
  } mop_t;

  cfg_regs_t regs;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  state_t          state_r;
  mop_t            op_r;
  logic [CNTW-1:0] cnt_r;
  logic [CEFF-1:0] c_r;
  logic [BW-1:0]   b_r;
  logic [WIDE-1:0] acc_r;
  logic [WIDE-1:0] mcand_r;
  logic [MPW-1:0]  mplier_r;
  logic [WIDE-1:0] lhs_r;
  logic [WIDE-1:0] src_r;
  logic [S1N-1:0]  root_r;
  logic [GW-1:0]   gx_r;
  logic [GW-1:0]   gy_r;
  logic [GKW-1:0]  gk_r;
  logic            gph_r;
  logic [GW-1:0]   gres_r;
  status_t         status_r;

  logic            out_valid_r;
  status_t         out_status_r;
  logic [BW-1:0]   out_root_r;
  logic [CW-1:0]   out_gcd_r;

  logic [CEFF-1:0] c_in;
  logic [WIDE-1:0] rem2;
  logic [WIDE-1:0] trial;
  logic [WIDE-1:0] rem_nxt;
  logic [S1N-1:0]  root_nxt;
  logic [GW-1:0]   g_fin;

  qrrt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  qrrt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign c_in = in_req.c_value[CEFF-1:0];

  // Square root step: bring down the next two bits, try 4*root + 1.
  assign rem2     = {acc_r[WIDE-3:0], src_r[WIDE-1 -: 2]};
  assign trial    = WIDE'({root_r, 2'b01});
  assign rem_nxt  = alu_rsp.cout ? alu_rsp.sum : rem2;
  assign root_nxt = {root_r[S1N-2:0], alu_rsp.cout};

  // gcd with one operand zero is the other, times the common power of two.
  assign g_fin = (gx_r == '0) ? (gy_r << gk_r) : (gx_r << gk_r);

  // Steer the shared adder by phase.
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_MUL: begin
        alu_req.a   = acc_r;
        alu_req.b   = mcand_r;
        alu_req.sub = 1'b0;
      end
      S_CMP: begin
        alu_req.a   = lhs_r;
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
      end
      S_SQ1, S_SQ2: begin
        alu_req.a   = rem2;
        alu_req.b   = trial;
        alu_req.sub = 1'b1;
      end
      S_GCD: begin
        alu_req.a   = WIDE'(gx_r);
        alu_req.b   = WIDE'(gy_r);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once the sink takes it; a new load below wins.
      if (out_rsp.valid && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            c_r      <= c_in;
            b_r      <= in_req.b_value;
            acc_r    <= '0;
            mcand_r  <= WIDE'(c_in);
            mplier_r <= MPW'(c_in);
            op_r     <= OP_CSQ;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier_r != '0) begin
            if (mplier_r[0]) begin
              acc_r <= alu_rsp.sum;
            end
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
          end else begin
            // Product done: chain it into the next multiply, save k*c^4 and start on b, or go to the compare.
            acc_r   <= '0;
            mcand_r <= acc_r;
            unique case (op_r)
              OP_CSQ: begin
                mplier_r <= acc_r[MPW-1:0];
                op_r     <= OP_CQU;
              end
              OP_CQU: begin
                mplier_r <= MPW'(regs.k);
                op_r     <= OP_KMUL;
              end
              OP_KMUL: begin
                lhs_r    <= acc_r;
                mcand_r  <= WIDE'(b_r);
                mplier_r <= MPW'(b_r);
                op_r     <= OP_BSQ;
              end
              OP_BSQ: begin
                mplier_r <= acc_r[MPW-1:0];
                op_r     <= OP_BQU;
              end
              OP_BQU: begin
                mplier_r <= MPW'(regs.n);
                op_r     <= OP_NMUL;
              end
              OP_NMUL: begin
                acc_r   <= acc_r;
                state_r <= S_CMP;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          if (!alu_rsp.cout) begin
            status_r <= ST_NEG;
            state_r  <= S_FIN;
          end else if (alu_rsp.sum == '0) begin
            status_r <= ST_ZERO;
            state_r  <= S_FIN;
          end else begin
            src_r   <= alu_rsp.sum << SH1;
            acc_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNTW'(S1N - 1);
            state_r <= S_SQ1;
          end
        end
        S_SQ1, S_SQ2: begin
          acc_r  <= rem_nxt;
          root_r <= root_nxt;
          src_r  <= src_r << 2;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (rem_nxt != '0) begin
              status_r <= ST_NOTP;
              state_r  <= S_FIN;
            end else if (state_r == S_SQ1) begin
              src_r   <= WIDE'(root_nxt) << SH2;
              acc_r   <= '0;
              root_r  <= '0;
              cnt_r   <= CNTW'(S2N - 1);
              state_r <= S_SQ2;
            end else begin
              // Exact fourth root: hold it in root_r, start gcd(a, b).
              gx_r    <= GW'(root_nxt);
              gy_r    <= b_r;
              gk_r    <= '0;
              gph_r   <= 1'b0;
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if ((gx_r == '0) || (gy_r == '0)) begin
            if (!gph_r) begin
              gx_r  <= g_fin;
              gy_r  <= GW'(c_r);
              gk_r  <= '0;
              gph_r <= 1'b1;
            end else begin
              gres_r   <= g_fin;
              status_r <= ST_HIT;
              state_r  <= S_FIN;
            end
          end else if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            gk_r <= gk_r + 1'b1;
          end else if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end else if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end else if (alu_rsp.cout) begin
            gx_r <= alu_rsp.sum[GW-1:0];
          end else begin
            // Keep the larger operand in gx.
            gx_r <= gy_r;
            gy_r <= gx_r;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_root_r   <= (status_r == ST_HIT) ? BW'(root_r) : '0;
            out_gcd_r    <= (status_r == ST_HIT) ? gres_r[CW-1:0] : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.root_a         = out_root_r;
  assign out_rsp.common_divisor = out_gcd_r;

  // Misses carry no root and no divisor.
  `QRRT_ASSERT_IMP(a_miss_clean, out_rsp.valid && (out_rsp.status != ST_HIT), (out_rsp.root_a == '0) && (out_rsp.common_divisor == '0))
  // A hit comes from a positive residual, so its root is never zero.
  `QRRT_ASSERT_IMP(a_hit_root, out_rsp.valid && (out_rsp.status == ST_HIT), out_rsp.root_a != '0)
  // An accepted request starts in the multiply phase.
  `QRRT_ASSERT_NXT(a_start_mul, in_req.valid && in_req.ready, state_r == S_MUL)

endmodule

[tb/quartic_residual_root_test_tb.sv]
`timescale 1ns / 1ps

module quartic_residual_root_test_tb;
  import qrrt_pkg::*;

  // Longest run of cycles with no request moving on either side.
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    status_t       status;
    logic [BW-1:0] root_a;
    logic [CW-1:0] common_divisor;
  } root_result_t;

  logic          clk;
  logic          rst_n;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  qrrt_in_if  in_req ();
  qrrt_out_if out_rsp ();

  quartic_residual_root_test u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_rsp (out_rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the two registers, updated with every write.
  logic [KW-1:0] model_k;
  logic [NW-1:0] model_n;

  root_result_t pending_roots[$];
  int           error_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           holdoff_cycles;
  int           quiet_cycles;

  // Clock: 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [WIDE-1:0] pow4(logic [23:0] x);
    logic [WIDE-1:0] p;
    p = WIDE'(x);
    p = p * p;
    p = p * p;
    return p;
  endfunction

  function automatic logic [23:0] euclid(logic [23:0] x, logic [23:0] y);
    logic [23:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Classify r = k*c^4 - N*b^4 and, on an exact fourth power, find a and gcd.
  function automatic root_result_t predict_root(logic [CW-1:0] c, logic [BW-1:0] b);
    root_result_t    res;
    logic [WIDE-1:0] lhs;
    logic [WIDE-1:0] rhs;
    logic [WIDE-1:0] resid;
    logic [23:0]     root;
    logic [23:0]     cand;
    lhs = WIDE'(model_k) * pow4(24'(c));
    rhs = WIDE'(model_n) * pow4(24'(b));
    res.root_a = '0;
    res.common_divisor = '0;
    if (lhs < rhs) begin
      res.status = ST_NEG;
    end else if (lhs == rhs) begin
      res.status = ST_ZERO;
    end else begin
      resid = lhs - rhs;
      root = '0;
      for (int i = BW - 1; i >= 0; i--) begin
        cand = root | (24'd1 << i);
        if (pow4(cand) <= resid) root = cand;
      end
      if (pow4(root) == resid) begin
        res.status = ST_HIT;
        res.root_a = root[BW-1:0];
        res.common_divisor = CW'(euclid(euclid(root, 24'(b)), 24'(c)));
      end else begin
        res.status = ST_NOTP;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // APB write at byte address 4*idx, then read it back.
  task automatic write_reg(reg_idx_t idx, logic [DW-1:0] value);
    logic [DW-1:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AW'(4 * int'(idx));
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_K) model_k = value[KW-1:0];
    else model_n = value[NW-1:0];
    want = (idx == REG_K) ? DW'(model_k) : DW'(model_n);
    // Read back.
    pwrite = 1'b0;
    psel   = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(logic [KW-1:0] k, logic [NW-1:0] n);
    write_reg(REG_K, DW'(k));
    write_reg(REG_N, DW'(n));
  endtask

  // Offer one request, hold it until accepted, then queue its prediction.
  // Valid stays high on return, so between back-to-back requests it drops only for random idle gaps.
  task automatic send_pair(logic [CW-1:0] c, logic [BW-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid = 1'b0;
      @(negedge clk);
    end
    in_req.valid   = 1'b1;
    in_req.c_value = c;
    in_req.b_value = b;
    do @(posedge clk); while (!in_req.ready);
    pending_roots.push_back(predict_root(c, b));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_req.valid = 1'b0;
  endtask

  // Wait until every prediction is matched, plus a margin.
  task automatic drain();
    release_input();
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drive ready at the falling edge; hold it low during a requested hold-off.
  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_rsp.ready  <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_rsp.status), '0);
      end else begin
        want = pending_roots.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", out_rsp.status, want.status);
        if (out_rsp.root_a !== want.root_a)
          report_mismatch("root_a", out_rsp.root_a, want.root_a);
        if (out_rsp.common_divisor !== want.common_divisor)
          report_mismatch("common_divisor", out_rsp.common_divisor, want.common_divisor);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Random pair: full range, small values, balanced c = b, b a small multiple of c, or zeros.
  task automatic send_random_pair();
    logic [CW-1:0] c;
    logic [BW-1:0] b;
    case ($urandom_range(9))
      0, 1, 2: begin
        c = CW'($urandom);
        b = BW'($urandom);
      end
      3, 4, 5: begin
        c = CW'($urandom_range(64, 1));
        b = BW'($urandom_range(64, 1));
      end
      6, 7: begin
        c = CW'($urandom);
        b = BW'(c);
      end
      8: begin
        c = CW'($urandom_range(4095));
        b = BW'(c) * BW'($urandom_range(3, 1));
      end
      default: begin
        c = ($urandom_range(1)) ? '0 : CW'($urandom);
        b = ($urandom_range(1)) ? '0 : BW'($urandom);
      end
    endcase
    send_pair(c, b);
  endtask

  // Defaults after reset, field extremes and zeros.
  task automatic test_reset_defaults();
    send_pair(CW'(1), BW'(1));
    send_pair('1, '1);
    send_pair('1, BW'(1));
    send_pair(CW'(1), '1);
    send_pair('0, '0);
    send_pair('0, BW'(5));
    send_pair(CW'(7), '0);
    send_pair(CW'(1000), BW'(1000));
    drain();
  endtask

  // Hits: N = 0 makes r = k*c^4, with k = 1 every pair with nonzero c hits.
  task automatic test_hits();
    set_config(KW'(1), NW'(0));
    send_pair(CW'(12), BW'(18));
    send_pair('1, '1);
    send_pair(CW'(1), BW'(0));
    send_pair('0, BW'(9));
    send_pair(CW'(30), BW'(45));
    drain();
    // k = 2, N = 1, c = b gives r = b^4; k = 17 with c=1, b=2 gives a=1.
    set_config(KW'(2), NW'(1));
    send_pair(CW'(6), BW'(6));
    send_pair('1, BW'(20'hFFFFF));
    drain();
    set_config(KW'(17), NW'(1));
    send_pair(CW'(1), BW'(2));
    send_pair(CW'(3), BW'(6));
    drain();
  endtask

  // Register extremes: zero k, full-scale k and N, and equal k and N.
  task automatic test_config_extremes();
    set_config(KW'(0), NW'(3));
    send_pair(CW'(5), BW'(5));
    send_pair(CW'(5), '0);
    drain();
    set_config('1, '1);
    send_pair('1, '1);
    send_pair(CW'(16), BW'(4));
    send_pair('1, BW'(1));
    drain();
    set_config(KW'(5), NW'(5));
    send_pair(CW'(77), BW'(77));
    drain();
  endtask

  // Random traffic under one idling profile and a random configuration.
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    logic [KW-1:0] k;
    logic [NW-1:0] n;
    k = KW'($urandom);
    n = ($urandom_range(3) == 0) ? '0 : NW'($urandom);
    set_config(k, n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_pair();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off while the sender keeps pushing, so input stalls.
  task automatic test_backpressure();
    set_config(KW'(1), NW'(0));
    holdoff_cycles = 3000;
    repeat (8) send_random_pair();
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_req.valid   = 1'b0;
    in_req.c_value = '0;
    in_req.b_value = '0;
    out_rsp.ready  = 1'b0;
    model_k        = KW'(51);
    model_n        = NW'(2);
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 0;
    quiet_cycles   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_hits();
    test_config_extremes();
    for (int p = 0; p < 2; p++) begin
      test_random_phase(0, 0, 210);
      test_random_phase(75, 0, 210);
      test_random_phase(0, 75, 210);
      test_random_phase(11, 11, 210);
    end
    test_backpressure();

    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
